// ===== rtl/euler_to_rotation_matrix_assert.svh =====
// Assertion macros for the Euler angle to rotation matrix block.
// Depends on nothing; included by modules that carry assertions.
`ifndef EULER_TO_ROTATION_MATRIX_ASSERT_SVH
`define EULER_TO_ROTATION_MATRIX_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define E2R_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication with the consequent in the cycle after the antecedent.
`define E2R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/e2r_pkg.sv =====
// Shared constants, types and helpers for the Euler to rotation matrix block.
// Depends on nothing.
`default_nettype none
package e2r_pkg;
    localparam int CordicStages = 24;
    localparam int DataW = 34;
    localparam logic signed [DataW-1:0] PiQ28 = 34'sd843314857;
    localparam logic signed [DataW-1:0] TwoPiQ28 = 34'sd1686629713;
    localparam logic signed [DataW-1:0] HalfPiQ28 = 34'sd421657428;
    localparam logic signed [DataW-1:0] CordicK = 34'sd652032874;
    localparam logic signed [DataW-1:0] OneQ30 = 34'sd1073741824;

    typedef struct packed {
        logic signed [DataW-1:0] x;
        logic signed [DataW-1:0] y;
        logic signed [DataW-1:0] z;
        logic neg_cos;
    } t_rot;

    typedef struct packed {
        logic signed [DataW-1:0] s;
        logic signed [DataW-1:0] c;
    } t_sc;

    function automatic logic signed [DataW-1:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
            5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
            5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
            5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
            5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F; 5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F; 5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004; 5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001; default: v = 32'h00000000;
        endcase
        return DataW'(signed'({1'b0, v}));
    endfunction

    function automatic logic signed [DataW-1:0] sat_one(input logic signed [DataW-1:0] v);
        if (v > OneQ30) return OneQ30;
        if (v < -OneQ30) return -OneQ30;
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/e2r_cell.sv =====
// One CORDIC rotation cell for three angles side by side.
// Depends on e2r_pkg.
`default_nettype none
module e2r_cell
    import e2r_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [4:0]  i_shift,
    input  wire t_rot        i_rot [3],
    output t_rot             o_rot [3]
);
    t_rot n_rot [3];
    t_rot r_rot [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rot[k] = i_rot[k];
            if (!i_rot[k].z[DataW-1]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> i_shift);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> i_shift);
                n_rot[k].z = i_rot[k].z - atan_q30(i_shift);
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> i_shift);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> i_shift);
                n_rot[k].z = i_rot[k].z + atan_q30(i_shift);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rot <= n_rot;
    end

    assign o_rot = r_rot;
endmodule
`default_nettype wire

// ===== rtl/e2r_reduce.sv =====
// Range reduction of one angle from Q3.28 to a Q30 CORDIC seed.
// Depends on e2r_pkg.
`default_nettype none
module e2r_reduce
    import e2r_pkg::*;
(
    input  wire logic signed [31:0] i_angle,
    output t_rot                    o_rot
);
    logic signed [DataW-1:0] a;
    always_comb begin
        a = DataW'(i_angle);
        o_rot.neg_cos = 1'b0;
        for (int k = 0; k < 2; k++) if (a > PiQ28) a = a - TwoPiQ28;
        for (int k = 0; k < 2; k++) if (a < -PiQ28) a = a + TwoPiQ28;
        if (a > HalfPiQ28) begin
            a = PiQ28 - a;
            o_rot.neg_cos = 1'b1;
        end else if (a < -HalfPiQ28) begin
            a = -PiQ28 - a;
            o_rot.neg_cos = 1'b1;
        end
        o_rot.z = a <<< 2;
        o_rot.x = CordicK;
        o_rot.y = '0;
    end
endmodule
`default_nettype wire

// ===== rtl/e2r_matrix.sv =====
// Product pipeline forming the nine matrix entries from sines and cosines.
// Depends on e2r_pkg.
`default_nettype none
module e2r_matrix
    import e2r_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_sc               i_sc [3],
    output logic signed [31:0]     o_c [9]
);
    function automatic logic signed [DataW-1:0] qmul(input logic signed [DataW-1:0] u,
                                                     input logic signed [DataW-1:0] v);
        logic signed [2*DataW-1:0] p;
        p = u * v + (2*DataW)'(64'sd536870912);
        return DataW'(p >>> 30);
    endfunction

    // stage 1: pairwise products
    logic signed [DataW-1:0] r_srsp, r_crsp, r_m0, r_m3, r_m7, r_m8;
    logic signed [DataW-1:0] r_crsy, r_srsy, r_crcy, r_srcy, r_sp;
    logic signed [DataW-1:0] r_sy1, r_cy1;
    always_ff @(posedge i_clk) begin
        r_srsp <= qmul(i_sc[0].s, i_sc[1].s);
        r_crsp <= qmul(i_sc[0].c, i_sc[1].s);
        r_m0   <= qmul(i_sc[1].c, i_sc[2].c);
        r_m3   <= qmul(i_sc[1].c, i_sc[2].s);
        r_m7   <= qmul(i_sc[0].s, i_sc[1].c);
        r_m8   <= qmul(i_sc[0].c, i_sc[1].c);
        r_crsy <= qmul(i_sc[0].c, i_sc[2].s);
        r_srsy <= qmul(i_sc[0].s, i_sc[2].s);
        r_crcy <= qmul(i_sc[0].c, i_sc[2].c);
        r_srcy <= qmul(i_sc[0].s, i_sc[2].c);
        r_sp   <= i_sc[1].s;
        r_sy1  <= i_sc[2].s;
        r_cy1  <= i_sc[2].c;
    end

    // stage 2: third factor and sums
    logic signed [DataW-1:0] n_m [9];
    logic signed [31:0] r_out [9];
    always_comb begin
        n_m[0] = r_m0;
        n_m[1] = -r_crsy + qmul(r_srsp, r_cy1);
        n_m[2] = r_srsy + qmul(r_crsp, r_cy1);
        n_m[3] = r_m3;
        n_m[4] = r_crcy + qmul(r_srsp, r_sy1);
        n_m[5] = -r_srcy + qmul(r_crsp, r_sy1);
        n_m[6] = -r_sp;
        n_m[7] = r_m7;
        n_m[8] = r_m8;
    end
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) r_out[k] <= 32'(sat_one(n_m[k]));
    end
    assign o_c = r_out;
endmodule
`default_nettype wire

// ===== rtl/euler_to_rotation_matrix.sv =====
// Channel  | ports                        | handshake
// command  | i_roll i_pitch i_yaw         | start, busy (always low)
// result   | o_c11 .. o_c33               | o_valid one-cycle strobe
// The path holds one register per CORDIC cell, one product register and one
// output register; one item per cycle is accepted.
// Reset clears the valid shift line only; data registers are not reset.
// The receiver cannot stall; results leave on a strobe.
// Depends on e2r_pkg, e2r_reduce, e2r_cell, e2r_matrix, euler_to_rotation_matrix_assert.svh.
`default_nettype none
module euler_to_rotation_matrix
    import e2r_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] i_roll,
    input  wire logic signed [31:0] i_pitch,
    input  wire logic signed [31:0] i_yaw,
    output logic                    o_valid,
    output logic signed [31:0]      o_c11, o_c12, o_c13,
    output logic signed [31:0]      o_c21, o_c22, o_c23,
    output logic signed [31:0]      o_c31, o_c32, o_c33
);
    `include "euler_to_rotation_matrix_assert.svh"
    localparam int Lat = CordicStages + 2;
    localparam logic signed [31:0] OneOut = 32'(OneQ30);

    t_rot chain [CordicStages+1][3];
    e2r_reduce u_rr (.i_angle(i_roll),  .o_rot(chain[0][0]));
    e2r_reduce u_rp (.i_angle(i_pitch), .o_rot(chain[0][1]));
    e2r_reduce u_ry (.i_angle(i_yaw),   .o_rot(chain[0][2]));

    for (genvar g = 0; g < CordicStages; g++) begin : g_cell
        e2r_cell u_cell (
            .i_clk(i_clk), .i_shift(5'(g)), .i_rot(chain[g]), .o_rot(chain[g+1])
        );
    end

    t_sc sc [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sc[k].s = sat_one(chain[CordicStages][k].y);
            sc[k].c = chain[CordicStages][k].neg_cos ? -sat_one(chain[CordicStages][k].x)
                                                     : sat_one(chain[CordicStages][k].x);
        end
    end

    logic signed [31:0] m [9];
    e2r_matrix u_mat (.i_clk(i_clk), .i_sc(sc), .o_c(m));

    logic [Lat-1:0] r_vld;
    logic [Lat-1:0] n_vld;
    assign n_vld = {r_vld[Lat-2:0], start};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= n_vld;
    end

    assign busy = 1'b0;
    assign o_valid = r_vld[Lat-1];
    assign o_c11 = m[0]; assign o_c12 = m[1]; assign o_c13 = m[2];
    assign o_c21 = m[3]; assign o_c22 = m[4]; assign o_c23 = m[5];
    assign o_c31 = m[6]; assign o_c32 = m[7]; assign o_c33 = m[8];

    `E2R_ASSERT_NEXT(a_vld_shift, i_clk, i_rst_n, start, r_vld[0])
    `E2R_ASSERT_IMP(a_c31_range, i_clk, i_rst_n, o_valid, (o_c31 <= OneOut) && (o_c31 >= -OneOut))
    `E2R_ASSERT_IMP(a_c11_range, i_clk, i_rst_n, o_valid, (o_c11 <= OneOut) && (o_c11 >= -OneOut))
endmodule
`default_nettype wire
